// ===== hdl/arl_pkg.sv =====
// Shared constants and types for the antialiased line rasterizer.
package arl_pkg;

  localparam int COLOR_W = 24;
  localparam int COV_W   = 8;
  localparam int REG_W   = 13;

  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [COV_W-1:0]   cov_t;
  typedef logic [REG_W-1:0]   screen_dim_t;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam screen_dim_t SCREEN_WIDTH_RESET  = 13'd800;
  localparam screen_dim_t SCREEN_HEIGHT_RESET = 13'd600;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  localparam cov_t COV_NONE     = 8'd0;
  localparam cov_t COV_ENDPOINT = 8'd127;
  localparam cov_t COV_FULL     = 8'd255;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== hdl/arl_if.sv =====
// Channel interfaces: line commands in, pixel words out, and setup words between front and back.
interface arl_command_if #(parameter int COORD_BITS = 12);
  import arl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;
  color_t                line_color;

  modport source (output valid, mode, x_start, y_start, x_end, y_end, line_color,
                  input ready);
  modport sink (input valid, mode, x_start, y_start, x_end, y_end, line_color,
                output ready);
endinterface

interface arl_pixel_if #(parameter int COORD_BITS = 12);
  import arl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  cov_t                  coverage;
  color_t                pixel_color;
  logic                  visible;
  logic                  last;

  modport source (output valid, pixel_x, pixel_y, coverage, pixel_color, visible, last,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, coverage, pixel_color, visible, last,
                output ready);
endinterface

interface arl_line_if #(parameter int COORD_BITS = 12, parameter int FRAC_BITS = 16);
  import arl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  start;
  logic                  steep;
  logic [COORD_BITS-1:0] col_start;
  logic [COORD_BITS-1:0] col_stop;
  logic [COORD_BITS-1:0] row_start;
  logic [COORD_BITS-1:0] row_stop;
  logic [FRAC_BITS+1:0]  slope;
  color_t                color;

  modport source (output valid, start, steep, col_start, col_stop, row_start, row_stop,
                  slope, color, input ready);
  modport sink (input valid, start, steep, col_start, col_stop, row_start, row_stop,
                slope, color, output ready);
endinterface

// ===== hdl/arl_front.sv =====
// Front end: takes commands, orders the endpoints and divides out the slope of a new line.
module arl_front #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input logic            clk,
  input logic            rst,
  arl_command_if.sink    command,
  arl_line_if.source     line
);
  import arl_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FRAC_BITS);

  localparam logic [1:0] ST_PASS  = 2'd0;
  localparam logic [1:0] ST_ORDER = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;
  localparam logic [1:0] ST_PUSH  = 2'd3;

  logic [1:0]            state;
  logic                  take;
  logic                  line_free;
  logic                  line_load;

  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic                  steep_in;

  logic                  steep;
  logic [COORD_BITS-1:0] xa;
  logic [COORD_BITS-1:0] ya;
  logic [COORD_BITS-1:0] xb;
  logic [COORD_BITS-1:0] yb;
  color_t                color;

  logic                  swap;
  logic [COORD_BITS-1:0] c0;
  logic [COORD_BITS-1:0] c1;
  logic [COORD_BITS-1:0] r0;
  logic [COORD_BITS-1:0] r1;
  logic                  neg_in;

  logic [COORD_BITS-1:0] col_start;
  logic [COORD_BITS-1:0] col_stop;
  logic [COORD_BITS-1:0] row_start;
  logic [COORD_BITS-1:0] row_stop;
  logic [COORD_BITS-1:0] dx;
  logic                  neg;

  logic [COORD_BITS-1:0] rem;
  logic [FRAC_BITS:0]    quo;
  logic [CNT_W-1:0]      cnt;
  logic [COORD_BITS:0]   trial;
  logic                  ge;
  logic [FRAC_BITS+1:0]  quo_ext;
  logic [FRAC_BITS+1:0]  slope_val;

  assign line_free     = !line.valid || line.ready;
  assign command.ready = (state == ST_PASS) && line_free;
  assign take          = command.valid && command.ready;
  assign line_load     = (take && command.mode == MODE_STEP) || (state == ST_PUSH && line_free);

  assign adx      = (command.x_start > command.x_end) ? command.x_start - command.x_end
                                                      : command.x_end - command.x_start;
  assign ady      = (command.y_start > command.y_end) ? command.y_start - command.y_end
                                                      : command.y_end - command.y_start;
  assign steep_in = ady > adx;

  // order along the major axis
  assign swap   = xa > xb;
  assign c0     = swap ? xb : xa;
  assign c1     = swap ? xa : xb;
  assign r0     = swap ? yb : ya;
  assign r1     = swap ? ya : yb;
  assign neg_in = r1 < r0;

  // restoring division, one quotient bit per cycle, integer bit first
  assign trial = (cnt == '0) ? {1'b0, rem} : {rem, 1'b0};
  assign ge    = trial >= {1'b0, dx};

  assign quo_ext   = {1'b0, quo};
  assign slope_val = (dx == '0) ? '0
                   : (neg ? (~quo_ext + {{(FRAC_BITS+1){1'b0}}, 1'b1}) : quo_ext);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_PASS;
      line.valid <= 1'b0;
    end else begin
      line.valid <= line_load || (line.valid && !line.ready);
      case (state)
        ST_PASS: begin
          if (take && command.mode == MODE_START) begin
            state <= ST_ORDER;
          end
        end
        ST_ORDER: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt == DIV_LAST) begin
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (line_free) begin
            state <= ST_PASS;
          end
        end
        default: begin
          state <= ST_PASS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      steep <= steep_in;
      xa    <= steep_in ? command.y_start : command.x_start;
      ya    <= steep_in ? command.x_start : command.y_start;
      xb    <= steep_in ? command.y_end : command.x_end;
      yb    <= steep_in ? command.x_end : command.y_end;
      color <= command.line_color;
    end
    if (state == ST_ORDER) begin
      col_start <= c0;
      col_stop  <= c1;
      row_start <= r0;
      row_stop  <= r1;
      dx        <= c1 - c0;
      neg       <= neg_in;
      rem       <= neg_in ? r0 - r1 : r1 - r0;
      quo       <= '0;
      cnt       <= '0;
    end
    if (state == ST_DIV) begin
      rem <= ge ? COORD_BITS'(trial - {1'b0, dx}) : trial[COORD_BITS-1:0];
      quo <= {quo[FRAC_BITS-1:0], ge};
      cnt <= cnt + 1'b1;
    end
    if (take && command.mode == MODE_STEP) begin
      line.start <= 1'b0;
    end
    if (state == ST_PUSH && line_free) begin
      line.start     <= 1'b1;
      line.steep     <= steep;
      line.col_start <= col_start;
      line.col_stop  <= col_stop;
      line.row_start <= row_start;
      line.row_stop  <= row_stop;
      line.slope     <= slope_val;
      line.color     <= color;
    end
  end

endmodule

// ===== hdl/arl_line_queue.sv =====
// Short queue of setup and step words between front and back.
module arl_line_queue #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input logic        clk,
  input logic        rst,
  arl_line_if.sink   wr,
  arl_line_if.source rd
);
  import arl_pkg::*;

  typedef struct packed {
    logic                  start;
    logic                  steep;
    logic [COORD_BITS-1:0] col_start;
    logic [COORD_BITS-1:0] col_stop;
    logic [COORD_BITS-1:0] row_start;
    logic [COORD_BITS-1:0] row_stop;
    logic [FRAC_BITS+1:0]  slope;
    color_t                color;
  } entry_t;

  localparam logic [QUEUE_CNT_W-1:0] FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

  entry_t                 slots [QUEUE_DEPTH];
  entry_t                 head;
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;
  logic                   push;
  logic                   pop;

  assign wr.ready = count != FULL;
  assign rd.valid = count != '0;
  assign push     = wr.valid && wr.ready;
  assign pop      = rd.valid && rd.ready;

  assign head         = slots[rd_ptr];
  assign rd.start     = head.start;
  assign rd.steep     = head.steep;
  assign rd.col_start = head.col_start;
  assign rd.col_stop  = head.col_stop;
  assign rd.row_start = head.row_start;
  assign rd.row_stop  = head.row_stop;
  assign rd.slope     = head.slope;
  assign rd.color     = head.color;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{start: wr.start, steep: wr.steep, col_start: wr.col_start,
                         col_stop: wr.col_stop, row_start: wr.row_start,
                         row_stop: wr.row_stop, slope: wr.slope, color: wr.color};
    end
  end

endmodule

// ===== hdl/arl_back.sv =====
// Back end: walks the line column by column and sends two pixel words per step.
module arl_back #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic [arl_pkg::REG_W-1:0]    screen_width,
  input logic [arl_pkg::REG_W-1:0]    screen_height,
  arl_line_if.sink                    line,
  arl_pixel_if.source                 pixel
);
  import arl_pkg::*;

  localparam int ACC_W = COORD_BITS + FRAC_BITS + 1;
  localparam int POS_W = COORD_BITS + 2;
  localparam int CMP_W = (POS_W > REG_W) ? POS_W : REG_W;
  localparam logic [FRAC_BITS+8:0] HALF_LSB =
    {{9{1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_SECOND = 2'd1;
  localparam logic [1:0] PH_INNER  = 2'd2;

  logic                  active;
  logic                  half;
  logic [1:0]            phase;
  logic                  steep;
  logic [COORD_BITS:0]   col_now;
  logic [COORD_BITS-1:0] col_stop;
  logic [COORD_BITS-1:0] row_stop;
  logic [ACC_W-1:0]      acc;
  logic [FRAC_BITS+1:0]  slope;
  color_t                color;

  logic                  out_free;
  logic                  emit;
  logic [ACC_W-1:0]      acc_step;
  logic [COORD_BITS:0]   row;
  logic [FRAC_BITS-1:0]  frac;
  logic [FRAC_BITS+8:0]  prod;
  cov_t                  fcov;
  logic                  fin_second;
  logic                  fin_inner;
  logic [COORD_BITS-1:0] sel_major;
  logic [POS_W-1:0]      base_minor;
  logic [POS_W-1:0]      sel_minor;
  cov_t                  sel_cov;
  logic                  sel_last;
  logic [POS_W-1:0]      px;
  logic [POS_W-1:0]      py;
  logic                  sel_visible;

  assign out_free   = !pixel.valid || pixel.ready;
  assign emit       = line.valid && !line.start && active && out_free;
  // drop starts and idle steps at once; an active step leaves after its second word
  assign line.ready = line.start || !active || (half && out_free);

  assign acc_step = acc + {{(COORD_BITS-1){slope[FRAC_BITS+1]}}, slope};
  assign row      = acc[ACC_W-1:FRAC_BITS];
  assign frac     = acc[FRAC_BITS-1:0];
  // frac * 255, rounded to 8 bits
  assign prod     = {1'b0, frac, 8'h00} - {9'h000, frac} + HALF_LSB;
  assign fcov     = prod[FRAC_BITS+7:FRAC_BITS];

  assign fin_second = col_now >= {1'b0, col_stop};
  assign fin_inner  = ({1'b0, col_now} + 1'b1) >= {2'b00, col_stop};

  assign sel_major  = (phase == PH_SECOND) ? col_stop : col_now[COORD_BITS-1:0];
  assign base_minor = (phase == PH_SECOND) ? {2'b00, row_stop} : {1'b0, row};
  assign sel_minor  = half ? base_minor + 1'b1 : base_minor;

  always_comb begin
    case (phase)
      PH_FIRST, PH_SECOND: begin
        sel_cov  = half ? COV_NONE : COV_ENDPOINT;
        sel_last = half && (phase == PH_SECOND) && fin_second;
      end
      PH_INNER: begin
        sel_cov  = half ? fcov : COV_FULL - fcov;
        sel_last = half && fin_inner;
      end
      default: begin
        sel_cov  = COV_NONE;
        sel_last = 1'b0;
      end
    endcase
  end

  assign px = steep ? sel_minor : {2'b00, sel_major};
  assign py = steep ? {2'b00, sel_major} : sel_minor;
  assign sel_visible = (px[POS_W-1:COORD_BITS] == 2'b00) && (py[POS_W-1:COORD_BITS] == 2'b00)
                    && (CMP_W'(px) < CMP_W'(screen_width))
                    && (CMP_W'(py) < CMP_W'(screen_height));

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      half        <= 1'b0;
      phase       <= PH_FIRST;
      pixel.valid <= 1'b0;
    end else begin
      pixel.valid <= emit || (pixel.valid && !pixel.ready);
      if (line.valid && line.start) begin
        active   <= 1'b1;
        half     <= 1'b0;
        phase    <= PH_FIRST;
        steep    <= line.steep;
        col_now  <= {1'b0, line.col_start};
        col_stop <= line.col_stop;
        row_stop <= line.row_stop;
        acc      <= {1'b0, line.row_start, {FRAC_BITS{1'b0}}};
        slope    <= line.slope;
        color    <= line.color;
      end else if (emit) begin
        half <= !half;
        if (half) begin
          case (phase)
            PH_FIRST: begin
              acc     <= acc_step;
              col_now <= col_now + 1'b1;
              phase   <= PH_SECOND;
            end
            PH_SECOND: begin
              if (fin_second) begin
                active <= 1'b0;
              end else begin
                phase <= PH_INNER;
              end
            end
            PH_INNER: begin
              acc     <= acc_step;
              col_now <= col_now + 1'b1;
              if (fin_inner) begin
                active <= 1'b0;
              end
            end
            default: begin
              active <= 1'b0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel.pixel_x     <= px[COORD_BITS-1:0];
      pixel.pixel_y     <= py[COORD_BITS-1:0];
      pixel.coverage    <= sel_cov;
      pixel.pixel_color <= color;
      pixel.visible     <= sel_visible;
      pixel.last        <= sel_last;
    end
  end

  a_half_needs_line: assert property (@(posedge clk) disable iff (rst)
    half |-> active)
    else $error("second word pending without a line in progress");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (emit && sel_last) |=> !active)
    else $error("line still active after its last pixel");

  a_step_leaves_after_pair: assert property (@(posedge clk) disable iff (rst)
    (line.valid && line.ready && !line.start && active) |-> (half && emit))
    else $error("step word left the queue before both pixels were sent");

endmodule

// ===== hdl/antialiased_line_raster.sv =====
// Antialiased line rasterizer top level: screen registers, front end, queue and back end.
//
// Channels: "command" carries start and step words, "pixel" carries one pixel per word.
// A start word (mode 0) loads two endpoints and a color and produces no pixel; it
// abandons any line in progress once it reaches the back end. A step word (mode 1)
// produces two pixel words for the current line, the pair that straddles the line
// row, and nothing if no line is active. The first endpoint pair, the second
// endpoint pair, then each interior column come out in order; last marks the end.
// Both pixel words of a step share the single pixel output, one word per cycle while
// pixel.ready is high, and no new step word is taken until both are sent. A start word
// holds command.ready low while the front end orders the endpoints and runs the slope
// division one bit per cycle. A step word passes the line register, a queue slot and
// the pixel register before its first pixel word is offered. The front end keeps taking
// step words while the back end stalls, up to the queue depth; when pixel.ready is low
// the pixel word holds and the back end stops. Reset clears the queue and the line state
// and sets the screen to 800 by 600. Write cfg_* only while no line work is pending.
module antialiased_line_raster #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input logic                          clk,
  input logic                          rst,
  arl_command_if.sink                  command,
  arl_pixel_if.source                  pixel,
  input logic                          cfg_we,
  input logic [arl_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [arl_pkg::REG_W-1:0]     cfg_data
);
  import arl_pkg::*;

  screen_dim_t screen_width;
  screen_dim_t screen_height;

  arl_line_if #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) front_line ();
  arl_line_if #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) back_line ();

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        CFG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  arl_front #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .command (command),
    .line    (front_line)
  );

  arl_line_queue #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (front_line),
    .rd  (back_line)
  );

  arl_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .line          (back_line),
    .pixel         (pixel)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the antialiased line rasterizer: directed and random lines with stalls.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import arl_pkg::*;

  localparam int COORD_MAX      = 4095;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLDOFF_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef enum logic [1:0] {SEG_FIRST, SEG_SECOND, SEG_INTERIOR} seg_t;

  typedef struct {
    logic        mode;
    logic [11:0] xs;
    logic [11:0] ys;
    logic [11:0] xe;
    logic [11:0] ye;
    color_t      color;
  } cmd_word_t;

  typedef struct {
    logic [11:0] x;
    logic [11:0] y;
    cov_t        cov;
    color_t      color;
    logic        vis;
    logic        fin;
  } pixel_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  screen_dim_t          cfg_data;

  arl_command_if cmd_if();
  arl_pixel_if   pix_if();

  antialiased_line_raster dut (
    .clk       (clk),
    .rst       (rst),
    .command   (cmd_if),
    .pixel     (pix_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Line state mirrored from the block, updated on every accepted command word.
  screen_dim_t scr_w = SCREEN_WIDTH_RESET;
  screen_dim_t scr_h = SCREEN_HEIGHT_RESET;
  logic        line_live = 1'b0;
  logic        line_steep = 1'b0;
  seg_t        seg = SEG_FIRST;
  logic [12:0] col_now = '0;
  logic [11:0] col_stop = '0;
  logic [11:0] end_row = '0;
  logic [28:0] row_acc = '0;
  logic [17:0] slope_q = '0;
  color_t      line_color_q = '0;

  cmd_word_t words_pending[$];
  cmd_word_t word_now;
  pixel_t    pixels_due[$];
  pixel_t    want;
  int        mismatches = 0;
  int        send_gap;
  bit        send_calm = 1'b0;
  int        recv_stall;
  bit        recv_calm = 1'b0;
  int        holdoff_left;
  int        holdoff_asked = 0;
  int        holdoff_served = 0;
  int        idle_cycles;

  function automatic pixel_t place(int unsigned major, int unsigned minor, cov_t cov, logic fin);
    pixel_t      p;
    int unsigned px;
    int unsigned py;
    px = line_steep ? minor : major;
    py = line_steep ? major : minor;
    p.x     = px[11:0];
    p.y     = py[11:0];
    p.cov   = cov;
    p.color = line_color_q;
    p.vis   = px <= COORD_MAX && py <= COORD_MAX && px < scr_w && py < scr_h;
    p.fin   = fin;
    return p;
  endfunction

  task automatic push_pair(int unsigned major, int unsigned minor, cov_t cov_lo, cov_t cov_hi,
                           logic fin);
    pixels_due = {pixels_due, place(major, minor, cov_lo, 1'b0)};
    pixels_due = {pixels_due, place(major, minor + 1, cov_hi, fin)};
  endtask

  task automatic raster_accept(input cmd_word_t w);
    logic [11:0] xa, ya, xb, yb, t, adx, ady, dx, mag;
    logic [31:0] quo;
    logic        neg;
    logic        fin;
    int unsigned fcov;
    if (w.mode == MODE_START) begin
      xa = w.xs; ya = w.ys; xb = w.xe; yb = w.ye;
      adx = (xa > xb) ? xa - xb : xb - xa;
      ady = (ya > yb) ? ya - yb : yb - ya;
      line_steep = ady > adx;
      if (line_steep) begin
        t = xa; xa = ya; ya = t;
        t = xb; xb = yb; yb = t;
      end
      if (xa > xb) begin
        t = xa; xa = xb; xb = t;
        t = ya; ya = yb; yb = t;
      end
      dx  = xb - xa;
      neg = yb < ya;
      mag = neg ? ya - yb : yb - ya;
      // zero-length line: flat gradient, no division
      quo = (dx == 0) ? 32'd0 : ({20'd0, mag} << 16) / {20'd0, dx};
      slope_q      = neg ? 18'(32'd0 - quo) : 18'(quo);
      col_now      = {1'b0, xa};
      col_stop     = xb;
      end_row      = yb;
      row_acc      = 29'(ya) << 16;
      line_color_q = w.color;
      seg          = SEG_FIRST;
      line_live    = 1'b1;
    end else if (line_live) begin
      case (seg)
        SEG_FIRST: begin
          push_pair(col_now, row_acc[28:16], COV_ENDPOINT, COV_NONE, 1'b0);
          row_acc = row_acc + {{11{slope_q[17]}}, slope_q};
          col_now = col_now + 13'd1;
          seg     = SEG_SECOND;
        end
        SEG_SECOND: begin
          fin = col_now >= {1'b0, col_stop};
          push_pair(col_stop, end_row, COV_ENDPOINT, COV_NONE, fin);
          if (fin) line_live = 1'b0;
          else seg = SEG_INTERIOR;
        end
        default: begin
          fcov = (row_acc[15:0] * 255 + 32768) >> 16;
          fin  = 32'(col_now) + 1 >= 32'(col_stop);
          push_pair(col_now, row_acc[28:16], cov_t'(COV_FULL - fcov), cov_t'(fcov), fin);
          row_acc = row_acc + {{11{slope_q[17]}}, slope_q};
          col_now = {1'b0, col_now[11:0] + 12'd1};
          if (fin) line_live = 1'b0;
        end
      endcase
    end
  endtask

  // Command driver: one word in flight, a random gap before each new word.
  always @(posedge clk) begin
    if (rst) begin
      cmd_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) raster_accept(word_now);
      if (!cmd_if.valid || cmd_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          cmd_if.valid <= 1'b0;
        end else if (words_pending.size() != 0) begin
          word_now = words_pending.pop_front();
          cmd_if.valid      <= 1'b1;
          cmd_if.mode       <= word_now.mode;
          cmd_if.x_start    <= word_now.xs;
          cmd_if.y_start    <= word_now.ys;
          cmd_if.x_end      <= word_now.xe;
          cmd_if.y_end      <= word_now.ye;
          cmd_if.line_color <= word_now.color;
          if ($urandom_range(0, 31) == 0) send_calm = !send_calm;
          send_gap = send_calm ? 0 : int'($urandom_range(0, 3));
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, served whenever the stimulus asks for one.
  always @(posedge clk) begin
    if (rst) begin
      holdoff_left <= 0;
    end else if (holdoff_left > 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (holdoff_served != holdoff_asked) begin
      holdoff_left   <= HOLDOFF_CYCLES;
      holdoff_served <= holdoff_served + 1;
    end
  end

  // Pixel monitor: check each accepted word against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      pix_if.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel word: x %0d y %0d", pix_if.pixel_x, pix_if.pixel_y);
          mismatches++;
        end else begin
          want = pixels_due.pop_front();
          if (pix_if.pixel_x !== want.x) begin
            $error("pixel_x: expected %0d, got %0d", want.x, pix_if.pixel_x);
            mismatches++;
          end
          if (pix_if.pixel_y !== want.y) begin
            $error("pixel_y: expected %0d, got %0d", want.y, pix_if.pixel_y);
            mismatches++;
          end
          if (pix_if.coverage !== want.cov) begin
            $error("coverage: expected %0d, got %0d", want.cov, pix_if.coverage);
            mismatches++;
          end
          if (pix_if.pixel_color !== want.color) begin
            $error("pixel_color: expected %06h, got %06h", want.color, pix_if.pixel_color);
            mismatches++;
          end
          if (pix_if.visible !== want.vis) begin
            $error("visible: expected %0b, got %0b", want.vis, pix_if.visible);
            mismatches++;
          end
          if (pix_if.last !== want.fin) begin
            $error("last: expected %0b, got %0b", want.fin, pix_if.last);
            mismatches++;
          end
        end
        if ($urandom_range(0, 31) == 0) recv_calm = !recv_calm;
        recv_stall = recv_calm ? 0 : int'($urandom_range(0, 3));
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      pix_if.ready <= (recv_stall == 0) && (holdoff_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (pix_if.valid && pix_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_start(int xs, int ys, int xe, int ye, color_t c);
    cmd_word_t w;
    w.mode  = MODE_START;
    w.xs    = 12'(xs);
    w.ys    = 12'(ys);
    w.xe    = 12'(xe);
    w.ye    = 12'(ye);
    w.color = c;
    words_pending = {words_pending, w};
  endtask

  // Step words carry random, ignored endpoint content.
  task automatic add_steps(int n);
    cmd_word_t w;
    repeat (n) begin
      w.mode  = MODE_STEP;
      w.xs    = 12'($urandom);
      w.ys    = 12'($urandom);
      w.xe    = 12'($urandom);
      w.ye    = 12'($urandom);
      w.color = color_t'($urandom);
      words_pending = {words_pending, w};
    end
  endtask

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // Bias toward the coordinate limits and the screen border.
  function automatic int pick_coord(int border);
    case ($urandom_range(0, 3))
      0: return int'($urandom_range(0, 15));
      1: return COORD_MAX - int'($urandom_range(0, 15));
      2: return clamp_coord(border - 8 + int'($urandom_range(0, 15)));
      default: return int'($urandom_range(0, COORD_MAX));
    endcase
  endfunction

  task automatic queue_random_line(inout int made);
    int xs, ys, xe, ye, reach, adx, ady, major, need, n;
    xs    = pick_coord(scr_w);
    ys    = pick_coord(scr_h);
    reach = ($urandom_range(0, 7) == 0) ? 80 : 16;
    xe    = clamp_coord(xs + int'($urandom_range(0, 2 * reach)) - reach);
    ye    = clamp_coord(ys + int'($urandom_range(0, 2 * reach)) - reach);
    adx   = (xs > xe) ? xs - xe : xe - xs;
    ady   = (ys > ye) ? ys - ye : ye - ys;
    major = (adx > ady) ? adx : ady;
    need  = (major <= 1) ? 2 : major + 1;
    // now and then abandon the line part way through
    n = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, need - 1)) : need;
    add_start(xs, ys, xe, ye, color_t'($urandom));
    add_steps(n);
    made += 1 + n;
    if (n == need && $urandom_range(0, 9) == 0) add_steps(int'($urandom_range(1, 2)));
  endtask

  // Wait until every word is accepted and every pixel is back, then let the block drain.
  task automatic settle();
    while (words_pending.size() != 0 || cmd_if.valid || pixels_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic run_random(int target);
    int made;
    made = 0;
    while (made < target) queue_random_line(made);
    settle();
  endtask

  task automatic write_screen(screen_dim_t w, screen_dim_t h);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    scr_w = w;
    scr_h = h;
    @(negedge clk);
  endtask

  initial begin
    cfg_we            = 1'b0;
    cfg_index         = CFG_SCREEN_WIDTH;
    cfg_data          = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_steps(1);                                         // step with no line
    add_start(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 24'hFFFFFF);
    add_steps(3);                                         // zero length, then a stray step
    add_start(0, 0, 1, 0, 24'h000000);                    // no interior column
    add_steps(2);
    add_start(10, 20, 14, 21, 24'h123456);                // shallow, positive slope
    add_steps(5);
    add_start(7, 9, 6, 5, 24'hA5C3E7);                    // steep, endpoints reversed
    add_steps(5);
    add_start(0, COORD_MAX, 2, COORD_MAX - 2, 24'h5A3C18); // 45 degrees, row wraps
    add_steps(3);
    add_start(100, 100, 120, 106, 24'h808080);            // abandoned by the next start
    add_steps(3);
    settle();

    write_screen(13'd4096, 13'd4096);
    run_random(90);
    write_screen(13'd1, 13'd1);
    run_random(70);
    write_screen(13'd0, 13'd0);
    run_random(60);
    write_screen(13'h1FFF, 13'h1FFF);
    run_random(60);
    holdoff_asked++;
    repeat (3) begin
      write_screen(screen_dim_t'($urandom_range(1, 4096)),
                   screen_dim_t'($urandom_range(1, 4096)));
      run_random(90);
    end
    write_screen(SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET);
    holdoff_asked++;
    run_random(90);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/arl_pkg.sv
hdl/arl_if.sv
hdl/arl_front.sv
hdl/arl_line_queue.sv
hdl/arl_back.sv
hdl/antialiased_line_raster.sv
bench/tb_top.sv
